// ----- rtl/dmawt_pkg.sv -----
// Shared types and constants of the address watch table.
package dmawt_pkg;

	localparam int DEF_SLOT_COUNT = 256;
	localparam int DEF_ADDR_BITS  = 48;
	localparam int DEF_COUNT_BITS = 32;
	localparam int SLOT_SHIFT     = 4;
	localparam int WATCHED_BITS   = 9;
	localparam int ACTION_BITS    = 2;
	localparam int OP_BITS        = 2;
	localparam int MAP_STEP_BITS  = 4;
	localparam int QUEUE_DEPTH    = 2;

	typedef enum logic [ACTION_BITS-1:0] {
		ACT_WATCH = 2'd0,
		ACT_TRACE = 2'd1,
		ACT_COPY  = 2'd2,
		ACT_READ  = 2'd3
	} action_t;

	typedef enum logic [OP_BITS-1:0] {
		OP_REPORT = 2'd0,
		OP_WATCH  = 2'd1,
		OP_TRACE  = 2'd2,
		OP_COPY   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		F_IDLE = 2'd0,
		F_MAP  = 2'd1,
		F_PUSH = 2'd2
	} front_state_t;

	typedef enum logic [1:0] {
		B_CLEAR = 2'd0,
		B_IDLE  = 2'd1,
		B_EVAL  = 2'd2,
		B_DST   = 2'd3
	} back_state_t;

endpackage

// ----- rtl/dmawt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module dmawt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/dmawt_queue.sv -----
// Small register queue between two parts of the watch table.
module dmawt_queue import dmawt_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ----- rtl/dmawt_front.sv -----
// Front end: accept requests, map addresses to slots, classify into table commands.
module dmawt_front import dmawt_pkg::*; #(
	parameter int SLOT_COUNT = DEF_SLOT_COUNT,
	parameter int ADDR_BITS  = DEF_ADDR_BITS
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic                                                push,
	output logic                                                full,
	input  logic [ACTION_BITS-1:0]                              action,
	input  logic [ADDR_BITS-1:0]                                addr,
	input  logic [ADDR_BITS-1:0]                                to_addr,
	input  logic [7:0]                                          slot_index,
	input  logic                                                watch_enable,
	input  logic                                                clearing,
	output logic                                                cmd_push,
	output logic [OP_BITS+2*$clog2(SLOT_COUNT)+2*ADDR_BITS-1:0] cmd_data,
	input  logic                                                cmd_full
);

	localparam int SLOT_BITS = $clog2(SLOT_COUNT);
	localparam int KEY_BITS  = ADDR_BITS - SLOT_SHIFT;
	localparam int MAP_STEPS = (KEY_BITS + MAP_STEP_BITS - 1) / MAP_STEP_BITS;
	localparam int PAD_BITS  = MAP_STEPS * MAP_STEP_BITS;
	localparam bit IS_POW2   = ((SLOT_COUNT & (SLOT_COUNT - 1)) == 0);

	front_state_t             state_q, state_d;
	action_t                  action_s1;
	logic [ADDR_BITS-1:0]     addr_s1, to_addr_s1;
	logic [SLOT_BITS-1:0]     src_map, dst_map, idx_map, src_slot;
	logic                     map_done, accept, mapping;
	logic                     addr_nz, to_nz;
	op_t                      op;

	assign accept  = push & ~full;
	assign mapping = (state_q == F_MAP);

	// Slot = (address >> 4) mod SLOT_COUNT
	if (IS_POW2) begin : g_pow2
		logic [7:0]          index_s1;
		logic [PAD_BITS-1:0] idx_ext;

		always_ff @(posedge clk) begin
			if (accept) begin
				index_s1 <= slot_index;
			end
		end

		assign idx_ext  = PAD_BITS'(index_s1);
		assign src_map  = addr_s1[SLOT_SHIFT +: SLOT_BITS];
		assign dst_map  = to_addr_s1[SLOT_SHIFT +: SLOT_BITS];
		assign idx_map  = idx_ext[SLOT_BITS-1:0];
		assign map_done = 1'b1;
	end else begin : g_div
		localparam int STEP_W = $clog2(MAP_STEPS);
		localparam logic [SLOT_BITS:0] MODULUS = (SLOT_BITS + 1)'(SLOT_COUNT);

		logic [PAD_BITS-1:0]  key_a_q, key_t_q, key_i_q;
		logic [SLOT_BITS-1:0] rem_a_q, rem_t_q, rem_i_q;
		logic [STEP_W-1:0]    step_q;

		// Shift a few key bits into a remainder, restoring one bit at a time.
		function automatic logic [SLOT_BITS-1:0] rem_step(
			input logic [SLOT_BITS-1:0]     rem,
			input logic [MAP_STEP_BITS-1:0] bits
		);
			logic [SLOT_BITS:0]   t;
			logic [SLOT_BITS-1:0] r;
			r = rem;
			for (int i = MAP_STEP_BITS - 1; i >= 0; i--) begin
				t = {r, bits[i]};
				if (t >= MODULUS) begin
					t = t - MODULUS;
				end
				r = t[SLOT_BITS-1:0];
			end
			return r;
		endfunction

		always_ff @(posedge clk) begin
			if (accept) begin
				key_a_q <= PAD_BITS'(addr[ADDR_BITS-1:SLOT_SHIFT]);
				key_t_q <= PAD_BITS'(to_addr[ADDR_BITS-1:SLOT_SHIFT]);
				key_i_q <= PAD_BITS'(slot_index);
				rem_a_q <= '0;
				rem_t_q <= '0;
				rem_i_q <= '0;
				step_q  <= '0;
			end else if (mapping) begin
				key_a_q <= key_a_q << MAP_STEP_BITS;
				key_t_q <= key_t_q << MAP_STEP_BITS;
				key_i_q <= key_i_q << MAP_STEP_BITS;
				rem_a_q <= rem_step(rem_a_q, key_a_q[PAD_BITS-1 -: MAP_STEP_BITS]);
				rem_t_q <= rem_step(rem_t_q, key_t_q[PAD_BITS-1 -: MAP_STEP_BITS]);
				rem_i_q <= rem_step(rem_i_q, key_i_q[PAD_BITS-1 -: MAP_STEP_BITS]);
				step_q  <= step_q + 1'b1;
			end
		end

		assign src_map  = rem_a_q;
		assign dst_map  = rem_t_q;
		assign idx_map  = rem_i_q;
		assign map_done = (step_q == STEP_W'(MAP_STEPS - 1));
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1  <= action_t'(action);
			addr_s1    <= addr;
			to_addr_s1 <= to_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		full     = clearing | mapping | ((state_q == F_PUSH) & cmd_full);
		cmd_push = 1'b0;
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					state_d = IS_POW2 ? F_PUSH : F_MAP;
				end
			end
			F_MAP: begin
				if (map_done) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				if (!cmd_full) begin
					cmd_push = 1'b1;
					if (accept) begin
						state_d = IS_POW2 ? F_PUSH : F_MAP;
					end else begin
						state_d = F_IDLE;
					end
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	// Drop disabled or zero-address actions down to a plain report.
	assign addr_nz = (addr_s1 != '0);
	assign to_nz   = (to_addr_s1 != '0);

	always_comb begin
		src_slot = src_map;
		case (action_s1)
			ACT_WATCH: op = (watch_enable && addr_nz) ? OP_WATCH : OP_REPORT;
			ACT_TRACE: op = addr_nz ? OP_TRACE : OP_REPORT;
			ACT_COPY:  op = (watch_enable && addr_nz && to_nz) ? OP_COPY : OP_REPORT;
			ACT_READ: begin
				op       = OP_REPORT;
				src_slot = idx_map;
			end
			default:   op = OP_REPORT;
		endcase
	end

	assign cmd_data = {op, src_slot, dst_map, addr_s1, to_addr_s1};

endmodule

// ----- rtl/dmawt_back.sv -----
// Back end: clear the table, then execute commands against it and build results.
module dmawt_back import dmawt_pkg::*; #(
	parameter int SLOT_COUNT = DEF_SLOT_COUNT,
	parameter int ADDR_BITS  = DEF_ADDR_BITS,
	parameter int COUNT_BITS = DEF_COUNT_BITS
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic                                                cmd_empty,
	input  logic [OP_BITS+2*$clog2(SLOT_COUNT)+2*ADDR_BITS-1:0] cmd_data,
	output logic                                                cmd_pop,
	input  logic                                                res_full,
	output logic                                                res_push,
	output logic [ADDR_BITS+3*COUNT_BITS+WATCHED_BITS-1:0]      res_data,
	output logic                                                clearing
);

	localparam int SLOT_BITS = $clog2(SLOT_COUNT);
	localparam int CMD_W     = OP_BITS + 2 * SLOT_BITS + 2 * ADDR_BITS;
	localparam int ENTRY_W   = ADDR_BITS + 2 * COUNT_BITS;

	back_state_t              state_q, state_d;
	logic [SLOT_BITS-1:0]     clr_q;
	op_t                      op_q;
	logic [SLOT_BITS-1:0]     src_q, dst_q;
	logic [ADDR_BITS-1:0]     addr_q, to_q;
	logic [WATCHED_BITS-1:0]  watched_q, watched_d, watched_inc;
	logic [COUNT_BITS-1:0]    coll_q, coll_d, coll_inc;
	logic [ADDR_BITS-1:0]     hold_tag_q;
	logic [COUNT_BITS-1:0]    hold_trc_q, hold_mov_q;
	logic                     hold_load;

	logic                     ram_we;
	logic [SLOT_BITS-1:0]     ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0]       ram_wdata, ram_rdata;

	op_t                      hd_op;
	logic [SLOT_BITS-1:0]     hd_src, hd_dst;
	logic [ADDR_BITS-1:0]     hd_addr, hd_to;

	logic [ADDR_BITS-1:0]     rd_tag, out_tag;
	logic [COUNT_BITS-1:0]    rd_trc, rd_mov, trc_new, mov_new, out_trc, out_mov;

	dmawt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOT_COUNT)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign hd_op   = op_t'(cmd_data[CMD_W-1 -: OP_BITS]);
	assign hd_src  = cmd_data[CMD_W-OP_BITS-1 -: SLOT_BITS];
	assign hd_dst  = cmd_data[CMD_W-OP_BITS-SLOT_BITS-1 -: SLOT_BITS];
	assign hd_addr = cmd_data[2*ADDR_BITS-1 -: ADDR_BITS];
	assign hd_to   = cmd_data[ADDR_BITS-1:0];

	assign rd_tag = ram_rdata[ENTRY_W-1 -: ADDR_BITS];
	assign rd_trc = ram_rdata[2*COUNT_BITS-1 -: COUNT_BITS];
	assign rd_mov = ram_rdata[COUNT_BITS-1:0];

	// Saturating increments
	assign trc_new     = (rd_trc == '1) ? rd_trc : rd_trc + 1'b1;
	assign mov_new     = (rd_mov == '1) ? rd_mov : rd_mov + 1'b1;
	assign coll_inc    = (coll_q == '1) ? coll_q : coll_q + 1'b1;
	assign watched_inc = (watched_q == '1) ? watched_q : watched_q + 1'b1;

	assign clearing = (state_q == B_CLEAR);

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = src_q;
		ram_wdata = '0;
		ram_raddr = hd_src;
		cmd_pop   = 1'b0;
		res_push  = 1'b0;
		hold_load = 1'b0;
		watched_d = watched_q;
		coll_d    = coll_q;
		out_tag   = rd_tag;
		out_trc   = rd_trc;
		out_mov   = rd_mov;
		case (state_q)
			B_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				if (clr_q == SLOT_BITS'(SLOT_COUNT - 1)) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				// Start only with room for the result already guaranteed.
				if (!cmd_empty && !res_full) begin
					cmd_pop = 1'b1;
					state_d = B_EVAL;
				end
			end
			B_EVAL: begin
				ram_raddr = dst_q;
				state_d   = B_IDLE;
				res_push  = 1'b1;
				case (op_q)
					OP_WATCH: begin
						if (rd_tag != addr_q) begin
							if (rd_tag != '0) begin
								coll_d = coll_inc;
							end else begin
								ram_we    = 1'b1;
								ram_wdata = {addr_q, {(2 * COUNT_BITS){1'b0}}};
								out_tag   = addr_q;
								out_trc   = '0;
								out_mov   = '0;
								watched_d = watched_inc;
							end
						end
					end
					OP_TRACE: begin
						if (rd_tag == addr_q) begin
							ram_we    = 1'b1;
							ram_wdata = {rd_tag, trc_new, rd_mov};
							out_trc   = trc_new;
						end
					end
					OP_COPY: begin
						if (rd_tag == addr_q) begin
							ram_we    = 1'b1;
							ram_wdata = {rd_tag, rd_trc, mov_new};
							out_mov   = mov_new;
							if (dst_q == src_q) begin
								// Destination is the source slot itself: occupied.
								coll_d = coll_inc;
							end else begin
								res_push  = 1'b0;
								hold_load = 1'b1;
								state_d   = B_DST;
							end
						end
					end
					default: ;
				endcase
			end
			B_DST: begin
				out_tag  = hold_tag_q;
				out_trc  = hold_trc_q;
				out_mov  = hold_mov_q;
				res_push = 1'b1;
				state_d  = B_IDLE;
				if (rd_tag == '0) begin
					ram_we    = 1'b1;
					ram_waddr = dst_q;
					ram_wdata = {to_q, {(2 * COUNT_BITS){1'b0}}};
				end else begin
					coll_d = coll_inc;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	assign res_data = {out_tag, out_trc, out_mov, watched_d, coll_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_CLEAR;
			clr_q     <= '0;
			watched_q <= '0;
			coll_q    <= '0;
		end else begin
			state_q   <= state_d;
			watched_q <= watched_d;
			coll_q    <= coll_d;
			if (state_q == B_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			op_q   <= hd_op;
			src_q  <= hd_src;
			dst_q  <= hd_dst;
			addr_q <= hd_addr;
			to_q   <= hd_to;
		end
		if (hold_load) begin
			hold_tag_q <= rd_tag;
			hold_trc_q <= rd_trc;
			hold_mov_q <= mov_new;
		end
	end

endmodule

// ----- rtl/direct_mapped_address_watch_table.sv -----
// A request passes the front registers, the command queue, the back end's table read and
//   evaluation, and the result queue; a copy whose source hits and whose destination is
//   another slot also passes the destination check (B_DST). When SLOT_COUNT is not a power
//   of two, slot mapping (F_MAP) is added and holds off new requests. The back end reads, then
//   writes, one command at a time. A reset sweep zeroes every slot; full stays high meanwhile.
// Top level of the direct-mapped address watch table.
module direct_mapped_address_watch_table import dmawt_pkg::*; #(
	parameter int SLOT_COUNT = DEF_SLOT_COUNT,
	parameter int ADDR_BITS  = DEF_ADDR_BITS,
	parameter int COUNT_BITS = DEF_COUNT_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// request side
	input  logic                    push,
	output logic                    full,
	input  logic [ACTION_BITS-1:0]  action,
	input  logic [ADDR_BITS-1:0]    addr,
	input  logic [ADDR_BITS-1:0]    to_addr,
	input  logic [7:0]              slot_index,
	// result side
	output logic                    empty,
	input  logic                    pop,
	output logic [ADDR_BITS-1:0]    slot_tag,
	output logic [COUNT_BITS-1:0]   traced_count,
	output logic [COUNT_BITS-1:0]   moved_count,
	output logic [WATCHED_BITS-1:0] watched_total,
	output logic [COUNT_BITS-1:0]   collision_total,
	// watch_enable register write
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic                    cfg_data
);

	localparam int SLOT_BITS = $clog2(SLOT_COUNT);
	localparam int CMD_W     = OP_BITS + 2 * SLOT_BITS + 2 * ADDR_BITS;
	localparam int RES_W     = ADDR_BITS + 3 * COUNT_BITS + WATCHED_BITS;

	logic             watch_enable_q;
	logic             clearing;
	logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
	logic [CMD_W-1:0] cmd_wdata, cmd_rdata;
	logic             res_push, res_full;
	logic [RES_W-1:0] res_wdata, res_rdata;

	// Configuration is taken at any time; the user writes it only while idle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			watch_enable_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			watch_enable_q <= cfg_data;
		end
	end

	// Front: take requests, compute slot numbers, turn each request into one command.
	dmawt_front #(
		.SLOT_COUNT (SLOT_COUNT),
		.ADDR_BITS  (ADDR_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.action       (action),
		.addr         (addr),
		.to_addr      (to_addr),
		.slot_index   (slot_index),
		.watch_enable (watch_enable_q),
		.clearing     (clearing),
		.cmd_push     (cmd_push),
		.cmd_data     (cmd_wdata),
		.cmd_full     (cmd_full)
	);

	// Command queue decouples slot mapping from table access.
	dmawt_queue #(
		.WIDTH (CMD_W),
		.DEPTH (QUEUE_DEPTH)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_wdata),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_rdata),
		.empty  (cmd_empty)
	);

	// Back: owns the table and the global counters; one command at a time.
	dmawt_back #(
		.SLOT_COUNT (SLOT_COUNT),
		.ADDR_BITS  (ADDR_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd_data  (cmd_rdata),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_data  (res_wdata),
		.clearing  (clearing)
	);

	// Result queue holds finished results while the consumer stalls.
	dmawt_queue #(
		.WIDTH (RES_W),
		.DEPTH (QUEUE_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wdata),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign {slot_tag, traced_count, moved_count, watched_total, collision_total} = res_rdata;

endmodule

// ----- sim/tb.sv -----
// Testbench for the address watch table: random and directed requests checked against a predictor.
module tb import dmawt_pkg::*; ();

	localparam int SLOT_BITS    = $clog2(DEF_SLOT_COUNT);
	localparam int SETTLE       = 8;       // quiet cycles before a drain ends or enable changes
	localparam int CYCLE_LIMIT  = 200000;  // far beyond the slowest correct run
	localparam int CALM_FIRST   = 500;     // no idling on either side for this request range
	localparam int CALM_LAST    = 800;

	typedef logic [DEF_ADDR_BITS-1:0]  addr_t;
	typedef logic [DEF_COUNT_BITS-1:0] count_t;

	// What sits in the stimulus queue: a table request, an enable write, or a pause
	// that holds the sender until every result has come back.
	typedef enum logic [1:0] {
		K_REQUEST      = 2'd0,
		K_ENABLE_WRITE = 2'd1,
		K_DRAIN        = 2'd2
	} entry_kind_t;

	typedef struct {
		entry_kind_t kind;
		action_t     act;
		addr_t       a;
		addr_t       to;
		logic [7:0]  idx;
		logic        enable;
	} stim_entry_t;

	typedef struct {
		addr_t                   tag;
		count_t                  traced;
		count_t                  moved;
		logic [WATCHED_BITS-1:0] watched;
		count_t                  collisions;
	} slot_report_t;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    push      = 1'b0;
	logic                    full;
	action_t                 action    = ACT_WATCH;
	addr_t                   addr      = '0;
	addr_t                   to_addr   = '0;
	logic [7:0]              slot_index = '0;
	logic                    empty;
	logic                    pop       = 1'b0;
	addr_t                   slot_tag;
	count_t                  traced_count;
	count_t                  moved_count;
	logic [WATCHED_BITS-1:0] watched_total;
	count_t                  collision_total;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic                    cfg_data  = 1'b0;

	direct_mapped_address_watch_table u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.action          (action),
		.addr            (addr),
		.to_addr         (to_addr),
		.slot_index      (slot_index),
		.empty           (empty),
		.pop             (pop),
		.slot_tag        (slot_tag),
		.traced_count    (traced_count),
		.moved_count     (moved_count),
		.watched_total   (watched_total),
		.collision_total (collision_total),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data)
	);

	always #2 clk = ~clk;

	// Shadow copy of the table, its totals and the enable register.
	addr_t                   shadow_tag   [DEF_SLOT_COUNT];
	count_t                  shadow_trace [DEF_SLOT_COUNT];
	count_t                  shadow_move  [DEF_SLOT_COUNT];
	logic [WATCHED_BITS-1:0] shadow_watched    = '0;
	count_t                  shadow_collisions = '0;
	logic                    shadow_enable     = 1'b0;

	stim_entry_t  pending_stim[$];
	slot_report_t expected_reports[$];
	addr_t        addr_pool[$];

	int   accepted_requests = 0;
	int   fail_count        = 0;
	int   cycle_count       = 0;
	int   quiet_cycles      = 0;
	logic req_fire          = 1'b0;
	logic cfg_fire          = 1'b0;
	logic calm;

	assign calm = (accepted_requests >= CALM_FIRST) && (accepted_requests < CALM_LAST);

	initial begin
		for (int i = 0; i < DEF_SLOT_COUNT; i++) begin
			shadow_tag[i]   = '0;
			shadow_trace[i] = '0;
			shadow_move[i]  = '0;
		end
	end

	function automatic count_t sat_bump(count_t v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic logic [SLOT_BITS-1:0] slot_of(addr_t a);
		return a[SLOT_SHIFT +: SLOT_BITS];
	endfunction

	// Apply one request to the shadow table and return the slot report it should produce.
	function automatic slot_report_t predict_slot_report(action_t act, addr_t a, addr_t to,
			logic [7:0] idx);
		slot_report_t          r;
		logic [SLOT_BITS-1:0]  s;
		logic [SLOT_BITS-1:0]  d;
		logic [SLOT_BITS-1:0]  shown;
		s     = slot_of(a);
		shown = s;
		case (act)
			ACT_WATCH: begin
				// Fill only an empty slot; a foreign tag refuses the fill, the same tag is a no-op.
				if (shadow_enable && a != '0 && shadow_tag[s] != a) begin
					if (shadow_tag[s] != '0) begin
						shadow_collisions = sat_bump(shadow_collisions);
					end else begin
						shadow_tag[s]   = a;
						shadow_trace[s] = '0;
						shadow_move[s]  = '0;
						if (shadow_watched != '1)
							shadow_watched = shadow_watched + 1'b1;
					end
				end
			end
			ACT_TRACE: begin
				// Counts regardless of the enable bit.
				if (a != '0 && shadow_tag[s] == a)
					shadow_trace[s] = sat_bump(shadow_trace[s]);
			end
			ACT_COPY: begin
				if (shadow_enable && a != '0 && to != '0 && shadow_tag[s] == a) begin
					d = slot_of(to);
					shadow_move[s] = sat_bump(shadow_move[s]);
					// An occupied destination refuses, even when it is the source or holds the tag.
					if (shadow_tag[d] == '0) begin
						shadow_tag[d]   = to;
						shadow_trace[d] = '0;
						shadow_move[d]  = '0;
					end else begin
						shadow_collisions = sat_bump(shadow_collisions);
					end
				end
			end
			default: shown = idx[SLOT_BITS-1:0];
		endcase
		r.tag        = shadow_tag[shown];
		r.traced     = shadow_trace[shown];
		r.moved      = shadow_move[shown];
		r.watched    = shadow_watched;
		r.collisions = shadow_collisions;
		return r;
	endfunction

	task automatic add_request(action_t act, addr_t a, addr_t to, logic [7:0] idx);
		stim_entry_t e;
		e.kind   = K_REQUEST;
		e.act    = act;
		e.a      = a;
		e.to     = to;
		e.idx    = idx;
		e.enable = 1'b0;
		pending_stim.push_back(e);
	endtask

	task automatic add_marker(entry_kind_t kind, logic enable);
		stim_entry_t e;
		e.kind   = kind;
		e.act    = ACT_READ;
		e.a      = '0;
		e.to     = '0;
		e.idx    = '0;
		e.enable = enable;
		pending_stim.push_back(e);
	endtask

	function automatic addr_t fresh_addr();
		return addr_t'({$urandom, $urandom});
	endfunction

	// Mostly reuse addresses that may already sit in the table so traces and copies hit.
	function automatic addr_t pick_addr();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return '0;
		if (r < 70 && addr_pool.size() > 0)
			return addr_pool[$urandom_range(addr_pool.size() - 1)];
		return fresh_addr();
	endfunction

	task automatic add_random_request();
		int      r;
		addr_t   a;
		addr_t   to;
		r  = $urandom_range(99);
		a  = pick_addr();
		to = pick_addr();
		if (r < 30) begin
			if ($urandom_range(1) == 1) begin
				a = fresh_addr();
				addr_pool.push_back(a);
			end
			add_request(ACT_WATCH, a, to, 8'($urandom));
		end else if (r < 60) begin
			add_request(ACT_TRACE, a, to, 8'($urandom));
		end else if (r < 80) begin
			if ($urandom_range(1) == 1) begin
				to = fresh_addr();
				addr_pool.push_back(to);
			end
			add_request(ACT_COPY, a, to, 8'($urandom));
		end else begin
			add_request(ACT_READ, a, to, 8'($urandom));
		end
	endtask

	// Accept requests and register writes, predict, and check results at the rising edge.
	always @(posedge clk) begin : check_results
		slot_report_t exp_r;
		req_fire = push && !full;
		cfg_fire = cfg_valid && cfg_ready;
		if (req_fire) begin
			expected_reports.push_back(predict_slot_report(action, addr, to_addr, slot_index));
			accepted_requests++;
		end
		if (cfg_fire)
			shadow_enable = cfg_data;
		if (pop && !empty) begin
			if (expected_reports.size() == 0) begin
				$error("result popped with no request outstanding");
				fail_count++;
			end else begin
				exp_r = expected_reports.pop_front();
				if (slot_tag !== exp_r.tag) begin
					$error("slot_tag: expected %h, got %h", exp_r.tag, slot_tag);
					fail_count++;
				end
				if (traced_count !== exp_r.traced) begin
					$error("traced_count: expected %0d, got %0d", exp_r.traced, traced_count);
					fail_count++;
				end
				if (moved_count !== exp_r.moved) begin
					$error("moved_count: expected %0d, got %0d", exp_r.moved, moved_count);
					fail_count++;
				end
				if (watched_total !== exp_r.watched) begin
					$error("watched_total: expected %0d, got %0d", exp_r.watched, watched_total);
					fail_count++;
				end
				if (collision_total !== exp_r.collisions) begin
					$error("collision_total: expected %0d, got %0d", exp_r.collisions,
						collision_total);
					fail_count++;
				end
			end
		end
	end

	// Feed the request port from the stimulus queue at the falling edge. Enable writes and
	// drain markers hold the sender until no result is outstanding and the quiet count reaches SETTLE.
	always @(negedge clk) begin : drive_requests
		stim_entry_t head;
		if (req_fire || cfg_fire)
			void'(pending_stim.pop_front());
		if (!arst_n || pending_stim.size() == 0) begin
			push      <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			head = pending_stim[0];
			if (head.kind == K_REQUEST) begin
				quiet_cycles = 0;
				push       <= calm || ($urandom_range(99) >= 27);
				action     <= head.act;
				addr       <= head.a;
				to_addr    <= head.to;
				slot_index <= head.idx;
				cfg_valid  <= 1'b0;
			end else begin
				push <= 1'b0;
				if (expected_reports.size() != 0)
					quiet_cycles = 0;
				else if (quiet_cycles < SETTLE)
					quiet_cycles++;
				// A drain ends once quiet; the next entry is taken at the following edge.
				if (head.kind == K_DRAIN && quiet_cycles >= SETTLE)
					void'(pending_stim.pop_front());
				cfg_valid <= (head.kind == K_ENABLE_WRITE) && (quiet_cycles >= SETTLE);
				cfg_data  <= head.enable;
			end
		end
	end

	// Stall the result side at random, except in the calm stretch.
	always @(negedge clk)
		pop <= arst_n && (calm || ($urandom_range(99) >= 27));

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin : run_test
		logic phase_enable [6];
		addr_t a_lo;
		addr_t a_rival;
		addr_t c_dst;
		addr_t c_rival;
		addr_t all_ones;
		phase_enable = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
		a_lo     = 48'h0000_0000_0010;  // slot 1
		a_rival  = 48'h8000_0000_0010;  // slot 1, other tag
		c_dst    = 48'h0000_0000_0020;  // slot 2
		c_rival  = 48'h4000_0000_0020;  // slot 2, other tag
		all_ones = '1;                  // slot 255

		// Disabled table: watch and copy do nothing, reads see empty slots.
		add_marker(K_ENABLE_WRITE, 1'b0);
		add_request(ACT_WATCH, a_lo, '0, 8'h00);
		add_request(ACT_COPY, a_lo, c_dst, 8'h00);
		add_request(ACT_READ, '0, '0, 8'h00);
		add_request(ACT_READ, all_ones, all_ones, 8'hFF);

		// Enabled: zero address, fills, held tag, refused fill, traces and copies.
		add_marker(K_ENABLE_WRITE, 1'b1);
		add_request(ACT_WATCH, '0, '0, 8'h00);
		add_request(ACT_WATCH, all_ones, all_ones, 8'hFF);
		add_request(ACT_WATCH, a_lo, '0, 8'h00);
		add_request(ACT_WATCH, a_lo, '0, 8'h00);
		add_request(ACT_WATCH, a_rival, '0, 8'h00);
		add_request(ACT_TRACE, a_lo, '0, 8'h00);
		add_request(ACT_TRACE, a_lo, '0, 8'h00);
		add_request(ACT_TRACE, '0, '0, 8'h00);
		add_request(ACT_TRACE, a_rival, '0, 8'h00);
		add_request(ACT_COPY, a_lo, '0, 8'h00);
		add_request(ACT_COPY, '0, c_dst, 8'h00);
		add_request(ACT_COPY, a_lo, c_dst, 8'h00);
		add_request(ACT_COPY, a_lo, c_dst, 8'h00);
		add_request(ACT_COPY, a_lo, a_lo, 8'h00);
		add_request(ACT_COPY, a_lo, c_rival, 8'h00);
		add_request(ACT_READ, '0, '0, 8'h02);
		add_request(ACT_READ, '0, '0, 8'h01);

		// Disabled again: trace still counts, watch is ignored.
		add_marker(K_ENABLE_WRITE, 1'b0);
		add_request(ACT_TRACE, a_lo, '0, 8'h00);
		add_request(ACT_WATCH, 48'h0000_0000_0030, '0, 8'h00);
		add_request(ACT_READ, '0, '0, 8'h01);

		addr_pool.push_back(a_lo);
		addr_pool.push_back(c_dst);
		addr_pool.push_back(all_ones);

		// Random phases, each behind an enable write; one mid-phase drain besides.
		for (int p = 0; p < 6; p++) begin
			add_marker(K_ENABLE_WRITE, phase_enable[p]);
			for (int i = 0; i < 250; i++) begin
				if (p == 3 && i == 125)
					add_marker(K_DRAIN, 1'b0);
				add_random_request();
			end
		end

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_stim.size() != 0 || expected_reports.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (fail_count == 0 && expected_reports.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- direct_mapped_address_watch_table.f -----
rtl/dmawt_pkg.sv
rtl/dmawt_ram.sv
rtl/dmawt_queue.sv
rtl/dmawt_front.sv
rtl/dmawt_back.sv
rtl/direct_mapped_address_watch_table.sv
sim/tb.sv
